[hdl/aes_pkg.sv]
package aes_pkg;

  localparam int KeyWords   = 60;
  localparam int FullRounds = 13;
  localparam int Rounds     = FullRounds + 1;
  localparam int KeyIdxW    = 6;

  typedef logic [127:0] blk_t;
  typedef logic [31:0]  word_t;
  typedef logic [KeyIdxW-1:0] kidx_t;

  typedef enum logic {
    KIND_KEY   = 1'b0,
    KIND_BLOCK = 1'b1
  } kind_t;

  // 128-bit round key for each of the 15 key adds
  typedef logic [Rounds:0][127:0] keyset_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // SubBytes + ShiftRows; byte r of column c sits at bits 8*(r+4c)
  function automatic blk_t sub_shift(input blk_t s);
    blk_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[8*(r+4*c) +: 8] = SBOX[s[8*(r+4*((c+r)%4)) +: 8]];
      end
    end
    sub_shift = t;
  endfunction

  function automatic blk_t mix_cols(input blk_t s);
    blk_t t;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = s[32*c +: 8];
      a1 = s[32*c+8 +: 8];
      a2 = s[32*c+16 +: 8];
      a3 = s[32*c+24 +: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      t[32*c +: 8]    = a0 ^ al ^ xtime(a0 ^ a1);
      t[32*c+8 +: 8]  = a1 ^ al ^ xtime(a1 ^ a2);
      t[32*c+16 +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      t[32*c+24 +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    mix_cols = t;
  endfunction

endpackage

[hdl/aes_key_store.sv]
module aes_key_store (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                wr_en,
  input  aes_pkg::kidx_t      wr_idx,
  input  aes_pkg::word_t      wr_data,
  output aes_pkg::keyset_t    keys
);

  localparam int RndW = aes_pkg::KeyIdxW - 2;

  // load beats travel with the block pipe; round g's words are written as the
  // load leaves the stage that feeds round g, so blocks ahead keep old keys
  logic [aes_pkg::Rounds-1:0] ld_vld_r;
  aes_pkg::kidx_t             ld_idx_r  [aes_pkg::Rounds];
  aes_pkg::word_t             ld_word_r [aes_pkg::Rounds];
  logic [aes_pkg::Rounds:0]   hit;
  logic [1:0]                 sel  [aes_pkg::Rounds+1];
  aes_pkg::word_t             wdat [aes_pkg::Rounds+1];
  aes_pkg::word_t             words_r [aes_pkg::KeyWords];

  always_comb begin
    hit[0]  = wr_en && (wr_idx[aes_pkg::KeyIdxW-1:2] == RndW'(0));
    sel[0]  = wr_idx[1:0];
    wdat[0] = wr_data;
    for (int g = 1; g <= aes_pkg::Rounds; g++) begin
      hit[g]  = ld_vld_r[g-1] && (ld_idx_r[g-1][aes_pkg::KeyIdxW-1:2] == RndW'(g));
      sel[g]  = ld_idx_r[g-1][1:0];
      wdat[g] = ld_word_r[g-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_vld_r <= '0;
    end else if (adv) begin
      ld_vld_r <= {ld_vld_r[aes_pkg::Rounds-2:0], wr_en};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ld_idx_r[0]  <= wr_idx;
      ld_word_r[0] <= wr_data;
      for (int p = 1; p < aes_pkg::Rounds; p++) begin
        ld_idx_r[p]  <= ld_idx_r[p-1];
        ld_word_r[p] <= ld_word_r[p-1];
      end
    end
  end

  // indexes 60..63 map to no round and are dropped
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < aes_pkg::KeyWords; i++) begin
        if (hit[i/4] && (sel[i/4] == 2'(i % 4))) begin
          words_r[i] <= wdat[i/4];
        end
      end
    end
  end

  // each word feeds one fixed round-key slot
  always_comb begin
    for (int k = 0; k <= aes_pkg::Rounds; k++) begin
      keys[k] = {words_r[4*k+3], words_r[4*k+2], words_r[4*k+1], words_r[4*k]};
    end
  end

endmodule

[hdl/aes_round.sv]
module aes_round (
  input  aes_pkg::blk_t state_i,
  input  logic [127:0]  key_i,
  input  logic          last_i,
  output aes_pkg::blk_t state_o
);

  aes_pkg::blk_t ss;

  always_comb begin
    ss = aes_pkg::sub_shift(state_i);
    if (last_i) begin
      state_o = ss ^ key_i;
    end else begin
      state_o = aes_pkg::mix_cols(ss) ^ key_i;
    end
  end

endmodule

[hdl/aes256_block_encrypt_unit.sv]
// AES-256 forward cipher, one 128-bit block per beat, ECB fashion.
//
// Input channel (in_valid / in_stall): in_kind 0 writes in_key_word into
// round-key slot in_key_index (60..63 ignored), no result. in_kind 1 is a
// plaintext block; it gives one beat on the output channel (out_valid /
// out_stall) with the ciphertext. All 60 key words must be loaded before a
// block uses them. A load travels down the pipe in order and updates each
// round's key as it passes, so it only affects blocks accepted after it.
//
// Pipeline: 15 register stages, the initial key add and then one per round;
// the last round's register is the output. One beat per cycle sustained
// while out_stall is low.
//
// Stall: out_stall freezes the whole pipeline; in_stall follows out_stall
// directly, so nothing is dropped or repeated. Key-load beats pass down the
// pipe as empty result slots.
//
// Reset: rst_n (sync, active low) clears valid bits only; key store
// contents are undefined until loaded.
module aes256_block_encrypt_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [5:0]  in_key_index,
  input  logic [31:0] in_key_word,
  input  logic [63:0] in_block_low,
  input  logic [63:0] in_block_high,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_cipher_low,
  output logic [63:0] out_cipher_high
);

  localparam int NSt = aes_pkg::Rounds + 1;

  aes_pkg::keyset_t keys;
  aes_pkg::blk_t    st_r   [NSt];
  aes_pkg::blk_t    st_nxt [NSt];
  logic [NSt-1:0]   vld_r;
  logic             adv;
  logic             key_wr;

  assign adv      = !out_stall;
  assign in_stall = out_stall;
  assign key_wr   = in_valid && (in_kind == aes_pkg::KIND_KEY);

  aes_key_store u_keys (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .wr_en   (key_wr),
    .wr_idx  (in_key_index),
    .wr_data (in_key_word),
    .keys    (keys)
  );

  assign st_nxt[0] = {in_block_high, in_block_low} ^ keys[0];

  for (genvar g = 1; g < NSt; g++) begin : g_rnd
    aes_round u_rnd (
      .state_i (st_r[g-1]),
      .key_i   (keys[g]),
      .last_i  (g == aes_pkg::Rounds),
      .state_o (st_nxt[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSt-2:0], in_valid && (in_kind == aes_pkg::KIND_BLOCK)};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < NSt; s++) begin
        st_r[s] <= st_nxt[s];
      end
    end
  end

  assign out_valid       = vld_r[NSt-1];
  assign out_cipher_low  = st_r[NSt-1][63:0];
  assign out_cipher_high = st_r[NSt-1][127:64];

  // stalled result must hold
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(st_r[NSt-1]))
    else $error("result changed under stall");

  // a block in the first stage moves on to the second when the pipe advances
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] && adv |=> vld_r[1])
    else $error("valid lost in pipe");

  // key loads never create a result slot
  a_key: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && adv && (in_kind == aes_pkg::KIND_KEY) |=> !vld_r[0])
    else $error("key load made a slot");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;

  // Beat as queued for the driver
  typedef struct packed {
    logic        kind;
    logic [5:0]  key_index;
    logic [31:0] key_word;
    logic [63:0] block_low;
    logic [63:0] block_high;
  } beat_t;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
  } cipher_t;

  localparam int Latency  = 15;
  localparam int CycleCap = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_kind;
  logic [5:0]  in_key_index;
  logic [31:0] in_key_word;
  logic [63:0] in_block_low;
  logic [63:0] in_block_high;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_cipher_low;
  logic [63:0] out_cipher_high;

  aes256_block_encrypt_unit u_top (.*);

  // Testbench-side copy of the round-key words
  logic [31:0] key_words [aes_pkg::KeyWords];
  beat_t   pending_beats[$];
  cipher_t cipher_fifo[$];
  int      mismatches;
  int      cycle_count;
  bit      stim_done;
  bit      drain_req;   // sender holds off until cipher_fifo is empty
  int      hold_left;   // long receiver hold-off, in cycles
  bit      hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Cipher predictor: AES-256 forward rounds on little-endian columns.
  // ---------------------------------------------------------------------
  function automatic logic [7:0] gf_dbl(logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] add_round_key(logic [127:0] s, int first);
    for (int c = 0; c < 4; c++) s[32*c +: 32] ^= key_words[first + c];
    return s;
  endfunction

  function automatic logic [127:0] sbox_shift_rows(logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[8*(r+4*c) +: 8] = aes_pkg::SBOX[s[8*(r+4*((c+r)&3)) +: 8]];
    return t;
  endfunction

  function automatic logic [127:0] mix_column_set(logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a [4];
    logic [7:0] x;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) a[j] = s[32*c + 8*j +: 8];
      x = a[0] ^ a[1] ^ a[2] ^ a[3];
      for (int j = 0; j < 4; j++)
        t[32*c + 8*j +: 8] = a[j] ^ x ^ gf_dbl(a[j] ^ a[(j+1)&3]);
    end
    return t;
  endfunction

  function automatic cipher_t encrypt_block(logic [63:0] lo, logic [63:0] hi);
    logic [127:0] s;
    s = add_round_key({hi, lo}, 0);
    for (int r = 1; r <= aes_pkg::FullRounds; r++)
      s = add_round_key(mix_column_set(sbox_shift_rows(s)), 4*r);
    s = add_round_key(sbox_shift_rows(s), 4*aes_pkg::Rounds);
    return '{lo: s[63:0], hi: s[127:64]};
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------
  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic push_key(int idx, logic [31:0] w);
    beat_t b;
    b = '{kind: aes_pkg::KIND_KEY, key_index: idx[5:0], key_word: w,
          block_low: rand64(), block_high: rand64()};
    pending_beats.push_back(b);
  endtask

  task automatic push_block(logic [63:0] lo, logic [63:0] hi);
    beat_t b;
    b = '{kind: aes_pkg::KIND_BLOCK, key_index: 6'($urandom()), key_word: $urandom(),
          block_low: lo, block_high: hi};
    pending_beats.push_back(b);
  endtask

  // Full fresh schedule; mode 0 random, 1 all zero, 2 all ones
  task automatic push_schedule(int mode);
    for (int i = 0; i < aes_pkg::KeyWords; i++)
      push_key(i, mode == 1 ? 32'h0 : mode == 2 ? 32'hffff_ffff : $urandom());
  endtask

  // Wait until the pipe has drained
  task automatic wait_idle();
    wait (pending_beats.size() == 0);
    wait (cipher_fifo.size() == 0);
    repeat (Latency + 2) @(posedge clk);
  endtask

  initial begin
    int n_sets;
    rst_n = 1'b0;
    stim_done = 1'b0;
    drain_req = 1'b0;
    hold_req = 1'b0;
    mismatches = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero keys, extreme blocks, a counting-pattern block
    push_schedule(1);
    push_block('0, '0);
    push_block('1, '1);
    // out-of-range loads must be ignored
    for (int i = aes_pkg::KeyWords; i < 64; i++) push_key(i, $urandom());
    push_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    wait_idle();
    push_schedule(2);
    push_block('0, '1);
    push_block(64'h8080_8080_8080_8080, 64'h0101_0101_0101_0101);
    push_key(63, 32'h0);
    push_block('1, '0);
    wait_idle();

    // Random: fresh key schedules, each followed by a run of blocks
    n_sets = 0;
    while (n_sets < 12) begin
      push_schedule(0);
      // a few stray out-of-range loads mixed in
      repeat ($urandom_range(0, 3))
        push_key($urandom_range(aes_pkg::KeyWords, 63), $urandom());
      repeat ($urandom_range(40, 80)) begin
        case ($urandom_range(0, 9))
          0: push_block('0, rand64());
          1: push_block(rand64(), '1);
          2: push_key($urandom_range(aes_pkg::KeyWords, 63), $urandom());
          default: push_block(rand64(), rand64());
        endcase
      end
      if (n_sets == 3) begin
        // long receiver hold with plenty still queued
        hold_req = 1'b1;
      end
      if (n_sets == 6) begin
        drain_req = 1'b1;
        wait (pending_beats.size() == 0);
        drain_req = 1'b0;
      end
      wait_idle();
      n_sets++;
    end
    stim_done = 1'b1;
  end

  // ---------------------------------------------------------------------
  // Driver: bursts of random length, random gaps
  // ---------------------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_kind <= 1'b0;
      in_key_index <= '0;
      in_key_word <= '0;
      in_block_low <= '0;
      in_block_high <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      automatic bit go = 1'b1;
      // current beat accepted this edge: retire it
      if (in_valid && !in_stall) begin
        automatic beat_t b = pending_beats.pop_front();
        if (b.kind == aes_pkg::KIND_KEY) begin
          if (b.key_index < aes_pkg::KeyWords) key_words[b.key_index] = b.key_word;
        end else begin
          cipher_fifo.push_back(encrypt_block(b.block_low, b.block_high));
        end
      end
      if (in_valid && in_stall) begin
        // hold payload while stalled
      end else begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          go = 1'b0;
        end else if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          if ($urandom_range(0, 3) == 0) begin
            gap_left <= $urandom_range(1, 20);
            go = 1'b0;
          end
        end else begin
          burst_left <= burst_left - 1;
        end
        if (drain_req && cipher_fifo.size() != 0) go = 1'b0;
        if (go && pending_beats.size() > 0) begin
          in_valid <= 1'b1;
          in_kind <= pending_beats[0].kind;
          in_key_index <= pending_beats[0].key_index;
          in_key_word <= pending_beats[0].key_word;
          in_block_low <= pending_beats[0].block_low;
          in_block_high <= pending_beats[0].block_high;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver stall pattern plus one long hold-off
  // ---------------------------------------------------------------------
  int stall_mode;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      stall_mode <= 0;
    end else begin
      if (hold_req && hold_left == 0) begin
        hold_left <= 300;
        hold_req = 1'b0;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= (hold_left != 1);
      end else begin
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 1) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: compare each ciphertext beat with the oldest prediction
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (cipher_fifo.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected cipher beat lo=%h hi=%h", out_cipher_low, out_cipher_high);
      end else begin
        automatic cipher_t e = cipher_fifo.pop_front();
        if (out_cipher_low !== e.lo || out_cipher_high !== e.hi) begin
          mismatches++;
          if (mismatches <= 10)
            $display("cipher mismatch: exp lo=%h hi=%h got lo=%h hi=%h",
                     e.lo, e.hi, out_cipher_low, out_cipher_high);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // End of run and watchdog
  // ---------------------------------------------------------------------
  initial begin
    cycle_count = 0;
    fork
      begin
        wait (stim_done);
        repeat (Latency + 5) @(posedge clk);
      end
      forever begin
        @(posedge clk);
        cycle_count++;
        if (cycle_count > CycleCap) begin
          $display("simulation failed");
          $finish;
        end
      end
    join_any
    if (mismatches == 0 && cipher_fifo.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/aes_pkg.sv
hdl/aes_key_store.sv
hdl/aes_round.sv
hdl/aes256_block_encrypt_unit.sv
tb/sv/tb.sv
